[sv/aabb_frustum_and_size_cull_assert.svh]
// Assertion macros shared by the checker of the cull pipeline.
// Needs nothing but the caller's clock and active-low reset.
`ifndef AABB_FRUSTUM_AND_SIZE_CULL_ASSERT_SVH
`define AABB_FRUSTUM_AND_SIZE_CULL_ASSERT_SVH

// cons must hold in the same cycle as ante
`define AFC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("cull pipeline check failed");

// cons must hold once the delay dly has passed after ante
`define AFC_ASSERT_DELAY(lbl, clk, rstn, ante, dly, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> ##dly (cons)) \
        else $error("cull pipeline latency check failed");

`endif

[sv/aafsc_pkg.sv]
// Package for the box frustum/size cull block: widths, register codes, types.
// No dependencies.
`timescale 1ns / 1ps

package aafsc_pkg;

    localparam int MaxPlanes         = 6;
    localparam int PlaneCountDefault = 6;
    localparam int FieldBits         = 16;
    localparam int CoordBits         = 16;
    localparam int CfgIndexBits      = 4;
    localparam int CfgDataBits       = 64;
    localparam int ThreshBits        = 32;
    localparam int TagBits           = 16;
    localparam int Latency           = 5;

    typedef logic signed [FieldBits-1:0] coord_t;

    typedef enum logic [CfgIndexBits-1:0] {
        CFG_PLANE_LEFT     = 4'd0,
        CFG_PLANE_RIGHT    = 4'd1,
        CFG_PLANE_BOTTOM   = 4'd2,
        CFG_PLANE_TOP      = 4'd3,
        CFG_PLANE_FAR      = 4'd4,
        CFG_PLANE_NEAR     = 4'd5,
        CFG_CAMERA         = 4'd6,
        CFG_SIZE_THRESHOLD = 4'd7
    } cfg_index_t;

    // a in the low bits, d in the high bits
    typedef struct packed {
        logic signed [FieldBits-1:0] d;
        logic signed [FieldBits-1:0] c;
        logic signed [FieldBits-1:0] b;
        logic signed [FieldBits-1:0] a;
    } plane_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec3_t;

    typedef struct packed {
        plane_t [MaxPlanes-1:0] planes;
        vec3_t                  camera;
        logic [ThreshBits-1:0]  k;
    } cull_cfg_t;

    // low CoordBits bits, sign-extended
    function automatic coord_t coord_ext(input logic [FieldBits-1:0] v);
        return coord_t'($signed(v[CoordBits-1:0]));
    endfunction

endpackage

[sv/aafsc_cfg_regs.sv]
// Configuration register file: six planes, camera position, size threshold.
// Depends on aafsc_pkg.
`timescale 1ns / 1ps

module aafsc_cfg_regs
    import aafsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIndexBits-1:0] cfg_index,
    input  logic [CfgDataBits-1:0]  cfg_data,
    output cull_cfg_t               cfg
);

    logic [CfgDataBits-1:0] plane_reg [MaxPlanes];
    logic [3*FieldBits-1:0] camera_reg;
    logic [ThreshBits-1:0]  k_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MaxPlanes; i++)
            begin
                plane_reg[i] <= '0;
            end
            camera_reg <= '0;
            k_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index)) inside
                CFG_PLANE_LEFT, CFG_PLANE_RIGHT, CFG_PLANE_BOTTOM,
                CFG_PLANE_TOP, CFG_PLANE_FAR, CFG_PLANE_NEAR:
                    plane_reg[cfg_index[2:0]] <= cfg_data;
                CFG_CAMERA:
                    camera_reg <= cfg_data[3*FieldBits-1:0];
                CFG_SIZE_THRESHOLD:
                    k_reg <= cfg_data[ThreshBits-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < MaxPlanes; i++)
        begin
            cfg.planes[i] = plane_t'(plane_reg[i]);
        end
        cfg.camera.x = coord_ext(camera_reg[FieldBits-1:0]);
        cfg.camera.y = coord_ext(camera_reg[2*FieldBits-1:FieldBits]);
        cfg.camera.z = coord_ext(camera_reg[3*FieldBits-1:2*FieldBits]);
        cfg.k        = k_reg;
    end

endmodule

[sv/aafsc_plane.sv]
// One plane test: corner products in stage A, sums and sign test in stage B.
// Depends on aafsc_pkg.
`timescale 1ns / 1ps

module aafsc_plane
    import aafsc_pkg::*;
(
    input  logic   clk,
    input  plane_t plane,
    input  vec3_t  bmin,
    input  vec3_t  bmax,
    output logic   cull
);

    localparam int ProdBits = 2 * FieldBits;
    localparam int SumBits  = ProdBits + 2;
    localparam int DShift   = 14;

    coord_t px, py, pz, qx, qy, qz;

    logic signed [ProdBits-1:0]  pos_reg [3];
    logic signed [ProdBits-1:0]  neg_reg [3];
    logic signed [FieldBits-1:0] d_reg;
    logic signed [SumBits-1:0]   pos_sum, neg_sum;
    logic                        cull_next, cull_reg;

    // P: far corner along the normal, Q: near corner
    always_comb
    begin
        px = plane.a[FieldBits-1] ? bmin.x : bmax.x;
        qx = plane.a[FieldBits-1] ? bmax.x : bmin.x;
        py = plane.b[FieldBits-1] ? bmin.y : bmax.y;
        qy = plane.b[FieldBits-1] ? bmax.y : bmin.y;
        pz = plane.c[FieldBits-1] ? bmin.z : bmax.z;
        qz = plane.c[FieldBits-1] ? bmax.z : bmin.z;
    end

    always_ff @(posedge clk)
    begin
        pos_reg[0] <= plane.a * px;
        pos_reg[1] <= plane.b * py;
        pos_reg[2] <= plane.c * pz;
        neg_reg[0] <= plane.a * qx;
        neg_reg[1] <= plane.b * qy;
        neg_reg[2] <= plane.c * qz;
        d_reg      <= plane.d;
    end

    always_comb
    begin
        pos_sum = SumBits'(pos_reg[0]) + SumBits'(pos_reg[1]) + SumBits'(pos_reg[2])
                + (SumBits'(d_reg) <<< DShift);
        neg_sum = SumBits'(neg_reg[0]) + SumBits'(neg_reg[1]) + SumBits'(neg_reg[2])
                + (SumBits'(d_reg) <<< DShift);
        cull_next = !(neg_sum > SumBits'(0)) && (pos_sum < SumBits'(0));
    end

    always_ff @(posedge clk)
    begin
        cull_reg <= cull_next;
    end

    assign cull = cull_reg;

endmodule

[sv/aafsc_size.sv]
// Angular size test, five stages: spans and camera offsets, squares, distance
// sum, threshold partial products, final add and compare. Depends on aafsc_pkg.
`timescale 1ns / 1ps

module aafsc_size
    import aafsc_pkg::*;
(
    input  logic                  clk,
    input  vec3_t                 bmin,
    input  vec3_t                 bmax,
    input  vec3_t                 camera,
    input  logic [ThreshBits-1:0] k,
    output logic                  too_small
);

    localparam int SpanBits = FieldBits + 1;
    localparam int DBits    = FieldBits + 2;
    localparam int SqBits   = 2 * DBits;
    localparam int DsqBits  = SqBits;
    localparam int HalfBits = DsqBits / 2;
    localparam int PpBits   = ThreshBits + HalfBits;
    localparam int E2Bits   = 2 * FieldBits;
    localparam int FracBits = 16;
    localparam int CmpBits  = ThreshBits + DsqBits;

    logic signed [SpanBits-1:0] span [3];
    logic signed [SpanBits-1:0] span_max;
    logic signed [DBits-1:0]    dd [3];
    logic [DBits-1:0]           ad [3];

    // stage A
    logic signed [SpanBits-1:0] span_reg;
    logic [DBits-1:0]           ad_reg [3];
    // stage B
    logic [SqBits-1:0]          sq_reg [3];
    logic [E2Bits-1:0]          e2_b_reg;
    logic                       neg_b_reg;
    // stage C
    logic [DsqBits-1:0]         dsq_reg;
    logic [E2Bits-1:0]          e2_c_reg;
    logic                       neg_c_reg;
    // stage D
    logic [PpBits-1:0]          pp_lo_reg, pp_hi_reg;
    logic [E2Bits-1:0]          e2_d_reg;
    logic                       neg_d_reg;
    // stage E
    logic [CmpBits-1:0]         lhs, rhs;
    logic                       small_next, small_reg;

    always_comb
    begin
        span[0] = SpanBits'(bmax.x) - SpanBits'(bmin.x);
        span[1] = SpanBits'(bmax.y) - SpanBits'(bmin.y);
        span[2] = SpanBits'(bmax.z) - SpanBits'(bmin.z);
        span_max = span[0];
        for (int i = 1; i < 3; i++)
        begin
            if (span[i] > span_max)
            begin
                span_max = span[i];
            end
        end
        dd[0] = (DBits'(camera.x) <<< 1) - (DBits'(bmin.x) + DBits'(bmax.x));
        dd[1] = (DBits'(camera.y) <<< 1) - (DBits'(bmin.y) + DBits'(bmax.y));
        dd[2] = (DBits'(camera.z) <<< 1) - (DBits'(bmin.z) + DBits'(bmax.z));
        for (int i = 0; i < 3; i++)
        begin
            ad[i] = dd[i][DBits-1] ? DBits'(-dd[i]) : DBits'(dd[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg  <= span_max;
        for (int i = 0; i < 3; i++)
        begin
            ad_reg[i] <= ad[i];
            sq_reg[i] <= ad_reg[i] * ad_reg[i];
        end
        e2_b_reg  <= span_reg[FieldBits-1:0] * span_reg[FieldBits-1:0];
        neg_b_reg <= span_reg[SpanBits-1];

        dsq_reg   <= DsqBits'(sq_reg[0]) + DsqBits'(sq_reg[1]) + DsqBits'(sq_reg[2]);
        e2_c_reg  <= e2_b_reg;
        neg_c_reg <= neg_b_reg;

        pp_lo_reg <= k * dsq_reg[HalfBits-1:0];
        pp_hi_reg <= k * dsq_reg[DsqBits-1:HalfBits];
        e2_d_reg  <= e2_c_reg;
        neg_d_reg <= neg_c_reg;

        small_reg <= small_next;
    end

    always_comb
    begin
        lhs = CmpBits'({e2_d_reg, {FracBits{1'b0}}});
        rhs = CmpBits'(pp_lo_reg) + (CmpBits'(pp_hi_reg) << HalfBits);
        small_next = (k != '0) && (neg_d_reg || (lhs < rhs));
    end

    assign too_small = small_reg;

endmodule

[sv/aabb_frustum_and_size_cull.sv]
// Top level of the box frustum and size cull pipeline.
// Depends on aafsc_pkg, aafsc_cfg_regs, aafsc_plane, aafsc_size.
`timescale 1ns / 1ps
//
// Usage:
//   Box channel: a box (min/max corners) and a tag are accepted at a rising
//   edge with start high and busy low. busy stays low, so a box can be
//   accepted every cycle.
//   Result channel: result_valid is high for exactly one cycle per box, with
//   keep, outside_frustum, too_small and result_tag. Results come in box
//   order; the receiver cannot stall, so the pipeline never holds.
//   Pipeline: five register stages lie between acceptance and the ports
//   (corner products, plane sums, distance sum, threshold partial
//   products, final compare). Throughput: one box per cycle.
//   Config channel: cfg_index/cfg_data are written when cfg_valid and
//   cfg_ready are high; cfg_ready is always high. Indexes beyond the
//   register list are ignored. Write only while no box is in flight.
//   Reset: configuration registers clear to zero, the valid pipeline empties,
//   the size test is disabled and the zero planes cull nothing.

module aabb_frustum_and_size_cull
    import aafsc_pkg::*;
#(
    parameter int PLANE_COUNT = PlaneCountDefault
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [FieldBits-1:0]    box_min_x,
    input  logic [FieldBits-1:0]    box_min_y,
    input  logic [FieldBits-1:0]    box_min_z,
    input  logic [FieldBits-1:0]    box_max_x,
    input  logic [FieldBits-1:0]    box_max_y,
    input  logic [FieldBits-1:0]    box_max_z,
    input  logic [TagBits-1:0]      item_tag,
    output logic                    result_valid,
    output logic                    keep,
    output logic                    outside_frustum,
    output logic                    too_small,
    output logic [TagBits-1:0]      result_tag,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CfgIndexBits-1:0] cfg_index,
    input  logic [CfgDataBits-1:0]  cfg_data
);

    cull_cfg_t              cfg;
    vec3_t                  bmin, bmax;
    logic                   accept;
    logic [PLANE_COUNT-1:0] cull;
    logic                   undersized;

    logic [Latency-1:0]     valid_reg;
    logic [TagBits-1:0]     tag_reg [Latency];
    logic                   outside_c_reg, outside_d_reg, outside_e_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign bmin.x = coord_ext(box_min_x);
    assign bmin.y = coord_ext(box_min_y);
    assign bmin.z = coord_ext(box_min_z);
    assign bmax.x = coord_ext(box_max_x);
    assign bmax.y = coord_ext(box_max_y);
    assign bmax.z = coord_ext(box_max_z);

    aafsc_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_plane
        aafsc_plane u_plane
        (
            .clk   (clk),
            .plane (cfg.planes[p]),
            .bmin  (bmin),
            .bmax  (bmax),
            .cull  (cull[p])
        );
    end

    aafsc_size u_size
    (
        .clk       (clk),
        .bmin      (bmin),
        .bmax      (bmax),
        .camera    (cfg.camera),
        .k         (cfg.k),
        .too_small (undersized)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[Latency-2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= item_tag;
        for (int i = 1; i < Latency; i++)
        begin
            tag_reg[i] <= tag_reg[i-1];
        end
        outside_c_reg <= |cull;
        outside_d_reg <= outside_c_reg;
        outside_e_reg <= outside_d_reg;
    end

    assign result_valid    = valid_reg[Latency-1];
    assign outside_frustum = outside_e_reg;
    assign too_small       = undersized;
    assign keep            = !(outside_e_reg || undersized);
    assign result_tag      = tag_reg[Latency-1];

endmodule

[sv/aafsc_checker.sv]
// Port-level checker for the cull pipeline, bound to the top level.
// Depends on aafsc_pkg and aabb_frustum_and_size_cull_assert.svh.
`timescale 1ns / 1ps
`include "aabb_frustum_and_size_cull_assert.svh"

module aafsc_checker
    import aafsc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [TagBits-1:0] item_tag,
    input logic               result_valid,
    input logic               keep,
    input logic               outside_frustum,
    input logic               too_small,
    input logic [TagBits-1:0] result_tag
);

    `AFC_ASSERT_DELAY(a_box_gives_result, clk, rst_n, start && !busy, Latency, result_valid)
    `AFC_ASSERT_IMP(a_result_has_box, clk, rst_n, result_valid, $past(start && !busy, Latency))
    `AFC_ASSERT_IMP(a_tag_in_order, clk, rst_n, result_valid, result_tag == $past(item_tag, Latency))
    `AFC_ASSERT_IMP(a_keep_decode, clk, rst_n, result_valid, keep == !(outside_frustum || too_small))

endmodule

bind aabb_frustum_and_size_cull aafsc_checker u_checker (.*);
